[rtl/core/rgef_pkg.sv]
// rgef_pkg: shared constants and register codes for the range gate / EMA filter core.
// No dependencies; imported by range_gate_ema_filter_core.
`timescale 1ns / 1ps

package rgef_pkg;

  // Channel and fixed-point set-up
  localparam int NUM_CHANNELS = 3;
  localparam int FRAC_BITS    = 8;

  // Field widths
  localparam int CH_W     = 2;
  localparam int RAW_W    = 16;
  localparam int STS_W    = 8;
  localparam int OFF_W    = 10;
  localparam int ALPHA_W  = 9;
  localparam int LIM_W    = 12;
  localparam int DIST_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Corrected distance: raw plus signed offset, with sign headroom
  localparam int CORR_W = RAW_W + 2;
  // Filter state: 12 integer bits plus fraction
  localparam int FILT_W = LIM_W + FRAC_BITS;
  // alpha (made signed) times signed difference
  localparam int PROD_W = (ALPHA_W + 1) + (FILT_W + 1);

  // alpha is Q1.8
  localparam int ALPHA_FRAC = 8;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);
  localparam int ALPHA_HALF = 1 << (ALPHA_FRAC - 1);

  localparam logic [STS_W-1:0]  STATUS_PHASE_FAIL = STS_W'(4);
  localparam logic [DIST_W-1:0] DIST_REJECT       = '1;
  localparam logic [DIST_W-1:0] DIST_MAX          = DIST_W'(4095);

  // Reset values of the configuration registers
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(128);
  localparam logic [LIM_W-1:0]   MIN_RST   = LIM_W'(20);
  localparam logic [LIM_W-1:0]   MAX_RST   = LIM_W'(2000);

  // Channel numbers
  localparam logic [CH_W-1:0] CH_LEFT  = CH_W'(0);
  localparam logic [CH_W-1:0] CH_FRONT = CH_W'(1);
  localparam logic [CH_W-1:0] CH_RIGHT = CH_W'(2);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_OFFSET  = 3'd0,
    REG_FRONT_OFFSET = 3'd1,
    REG_RIGHT_OFFSET = 3'd2,
    REG_ALPHA        = 3'd3,
    REG_MIN_DIST     = 3'd4,
    REG_MAX_DIST     = 3'd5
  } cfg_reg_t;

endpackage

[rtl/core/range_gate_ema_filter_core.sv]
// range_gate_ema_filter_core: validity gate and per-channel EMA filter for range samples.
// Depends on rgef_pkg.
`timescale 1ns / 1ps

// Takes one range sample per transfer (raw range and status in in_tdata, channel in
// in_tuser), adds the channel offset, rejects phase-failure status, out-of-range
// distances and unknown channels (distance -1, valid 0, filter untouched), seeds the
// channel filter on its first good sample and otherwise blends the sample in with
// weight alpha/256, and returns the filter rounded half up to whole millimetres.
// Accepts one sample per clock while the result stream is not stalled; a sample passes
// through the input register, the combinational gate/filter update and the result
// register in that order. Samples for the same channel may follow back to back, since the
// filter state is written on the edge that loads the result. cfg_ready is always high.
module range_gate_ema_filter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // [15:0] raw_range_mm, [23:16] range_status
  input  logic [rgef_pkg::CH_W-1:0]     in_tuser,   // [1:0] sensor_index
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [12:0] distance_mm, [15:13] zero
  output logic [2:0]                    out_tuser,  // [1:0] sensor_index_out, [2] reading_valid
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rgef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgef_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rgef_pkg::*;

  // Configuration registers
  logic signed [OFF_W-1:0] off_left_r, off_front_r, off_right_r;
  logic [ALPHA_W-1:0]      alpha_r;
  logic [LIM_W-1:0]        min_r, max_r;

  // Input register
  logic             s1_vld_r;
  logic [CH_W-1:0]  s1_ch_r;
  logic [RAW_W-1:0] s1_raw_r;
  logic [STS_W-1:0] s1_sts_r;

  // Per-channel filter state
  logic [FILT_W-1:0]       filt_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] seeded_r;

  // Result register
  logic              out_vld_r;
  logic [CH_W-1:0]   out_ch_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_ok_r;

  logic advance;
  logic in_xfer;

  logic signed [OFF_W-1:0]  ch_off;
  logic signed [CORR_W-1:0] corr;
  logic                     ch_ok, sample_ok;
  logic [FILT_W-1:0]        sample, f_cur, f_nxt;
  logic [ALPHA_W-1:0]       alpha_c;
  logic signed [FILT_W:0]   diff;
  logic signed [PROD_W-1:0] prod, prod_rnd, step;
  logic signed [FILT_W:0]   f_upd;
  logic [FILT_W:0]          rnd_sum;
  logic [DIST_W-1:0]        dist_nxt;

  // Handshakes
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || advance;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_left_r  <= '0;
      off_front_r <= '0;
      off_right_r <= '0;
      alpha_r     <= ALPHA_RST;
      min_r       <= MIN_RST;
      max_r       <= MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEFT_OFFSET:  off_left_r  <= cfg_data[OFF_W-1:0];
        REG_FRONT_OFFSET: off_front_r <= cfg_data[OFF_W-1:0];
        REG_RIGHT_OFFSET: off_right_r <= cfg_data[OFF_W-1:0];
        REG_ALPHA:        alpha_r     <= cfg_data[ALPHA_W-1:0];
        REG_MIN_DIST:     min_r       <= cfg_data[LIM_W-1:0];
        REG_MAX_DIST:     max_r       <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ch_r  <= in_tuser;
      s1_raw_r <= in_tdata[RAW_W-1:0];
      s1_sts_r <= in_tdata[RAW_W +: STS_W];
    end
  end

  // Offset select; channels without a register get none
  always_comb begin
    case (s1_ch_r)
      CH_LEFT:  ch_off = off_left_r;
      CH_FRONT: ch_off = off_front_r;
      CH_RIGHT: ch_off = off_right_r;
      default:  ch_off = '0;
    endcase
  end

  // Gate
  assign corr  = signed'({2'b00, s1_raw_r}) + CORR_W'(ch_off);
  assign ch_ok = 32'(s1_ch_r) < NUM_CHANNELS;
  assign sample_ok = ch_ok && (s1_sts_r != STATUS_PHASE_FAIL)
                  && (corr >= signed'({{(CORR_W-LIM_W){1'b0}}, min_r}))
                  && (corr <= signed'({{(CORR_W-LIM_W){1'b0}}, max_r}));

  // Filter update, written as f + a*(s - f)/256 with the half-up rounding term
  assign sample  = {corr[LIM_W-1:0], {FRAC_BITS{1'b0}}};
  assign f_cur   = filt_r[s1_ch_r];
  assign alpha_c = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign diff    = signed'({1'b0, sample}) - signed'({1'b0, f_cur});
  assign prod    = signed'({1'b0, alpha_c}) * diff;
  assign prod_rnd = prod + signed'(PROD_W'(ALPHA_HALF));
  assign step    = prod_rnd >>> ALPHA_FRAC;
  assign f_upd   = signed'({1'b0, f_cur}) + step[FILT_W:0];
  assign f_nxt   = seeded_r[s1_ch_r] ? f_upd[FILT_W-1:0] : sample;

  // Round half up to whole millimetres
  assign rnd_sum  = {1'b0, f_nxt} + (FILT_W+1)'(1 << (FRAC_BITS - 1));
  assign dist_nxt = sample_ok ? rnd_sum[FRAC_BITS +: DIST_W] : DIST_REJECT;

  // Filter state, written as the result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= '0;
    end else if (s1_vld_r && advance && sample_ok) begin
      seeded_r[s1_ch_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && advance && sample_ok) begin
      filt_r[s1_ch_r] <= f_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_vld_r) begin
      out_ch_r   <= s1_ch_r;
      out_dist_r <= dist_nxt;
      out_ok_r   <= sample_ok;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(16-DIST_W){1'b0}}, out_dist_r};
  assign out_tuser  = {out_ok_r, out_ch_r};

`ifndef NO_ASSERTIONS
  // A rejected result always carries the reject code
  a_reject_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ok_r |-> out_dist_r == DIST_REJECT)
    else $error("rejected result without reject code");

  // An accepted result never exceeds the top of the distance range
  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_ok_r |-> out_dist_r <= DIST_MAX)
    else $error("accepted distance out of range");

  // The filter update stays within the 12-bit integer range
  a_filter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && sample_ok && seeded_r[s1_ch_r] |-> f_upd >= 0 && f_upd[FILT_W] == 1'b0)
    else $error("filter update left its range");

  // Seeded channels stay seeded
  a_seed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(seeded_r) >= $past($countones(seeded_r)))
    else $error("channel lost its seed");

  // Input is only held off while the input register is occupied
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_vld_r && out_vld_r)
    else $error("input stalled with room available");
`endif

endmodule

[sim/range_gate_ema_filter_core_tb.sv]
// Self-checking testbench for range_gate_ema_filter_core: directed samples, then phases of
// random samples under varied register settings. Depends on rgef_pkg and the core.
`timescale 1ns / 1ps

module range_gate_ema_filter_core_tb;
  import rgef_pkg::*;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 12;
  localparam int SETTLE_CYCLES   = 4;     // lets the input and result registers empty, plus margin
  localparam int STALL_LIMIT     = 2000;  // cycles without any transfer

  localparam logic [CH_W-1:0]      CH_SPARE     = CH_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = CFG_IDX_W'(7);

  // Expected result of one sample
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [DIST_W-1:0] dist_mm;
    logic              valid;
  } reading_t;

  // Per-sample note: a hand-written expectation overrides the prediction
  typedef struct packed {
    logic              typed;
    logic [DIST_W-1:0] dist_mm;
    logic              valid;
  } sample_note_t;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [RAW_W-1:0]  raw;
    logic [STS_W-1:0]  sts;
    logic              typed;
    logic [DIST_W-1:0] dist_mm;
    logic              valid;
  } dir_row_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;
  logic [CH_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow of the registers and the filter state
  int                 ofs_mm [NUM_CHANNELS] = '{default: 0};
  logic [ALPHA_W-1:0] alpha_q = ALPHA_RST;
  logic [LIM_W-1:0]   min_mm  = MIN_RST;
  logic [LIM_W-1:0]   max_mm  = MAX_RST;
  logic [FILT_W-1:0]  ema_fix [NUM_CHANNELS] = '{default: '0};
  logic               seeded  [NUM_CHANNELS] = '{default: 1'b0};

  reading_t     expected_readings [$];
  sample_note_t sample_notes [$];
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  range_gate_ema_filter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register write into the shadow copy; unknown indexes are dropped
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LEFT_OFFSET:  ofs_mm[0] = int'($signed(data[OFF_W-1:0]));
      REG_FRONT_OFFSET: ofs_mm[1] = int'($signed(data[OFF_W-1:0]));
      REG_RIGHT_OFFSET: ofs_mm[2] = int'($signed(data[OFF_W-1:0]));
      REG_ALPHA:        alpha_q = data[ALPHA_W-1:0];
      REG_MIN_DIST:     min_mm = data[LIM_W-1:0];
      REG_MAX_DIST:     max_mm = data[LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // Gate the sample, then seed or blend the channel filter and round half up
  function automatic reading_t filter_sample(logic [CH_W-1:0] ch, logic [RAW_W-1:0] raw,
                                             logic [STS_W-1:0] sts);
    reading_t r;
    int corr;
    logic [31:0] samp, a, f;
    r.ch = ch;
    corr = int'(raw) + ((ch < NUM_CHANNELS) ? ofs_mm[ch] : 0);
    if (ch >= NUM_CHANNELS || sts == STATUS_PHASE_FAIL ||
        corr < int'(min_mm) || corr > int'(max_mm)) begin
      r.dist_mm = DIST_REJECT;
      r.valid = 1'b0;
      return r;
    end
    samp = 32'(corr) << FRAC_BITS;
    a = (alpha_q > ALPHA_ONE) ? 32'(ALPHA_ONE) : 32'(alpha_q);
    if (!seeded[ch]) begin
      f = samp;
      seeded[ch] = 1'b1;
    end else begin
      f = (a * samp + (32'(ALPHA_ONE) - a) * 32'(ema_fix[ch]) + 32'(ALPHA_HALF))
          >> ALPHA_FRAC;
    end
    ema_fix[ch] = f[FILT_W-1:0];
    r.dist_mm = DIST_W'((f + (32'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    r.valid = 1'b1;
    return r;
  endfunction

  // Monitor: track register writes, predict on input transfers, check output transfers
  always @(posedge clk) begin : monitor_proc
    reading_t pred, want;
    sample_note_t note;
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        apply_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        pred = filter_sample(in_tuser, in_tdata[RAW_W-1:0], in_tdata[RAW_W+STS_W-1:RAW_W]);
        note = sample_notes.pop_front();
        if (note.typed) begin
          pred.dist_mm = note.dist_mm;
          pred.valid = note.valid;
        end
        expected_readings.push_back(pred);
      end
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $error("result transfer with no sample pending: tdata %h tuser %h",
                 out_tdata, out_tuser);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (out_tuser[CH_W-1:0] !== want.ch) begin
            $error("sensor_index_out: expected %0d, got %0d", want.ch, out_tuser[CH_W-1:0]);
            errors++;
          end
          if (out_tdata[DIST_W-1:0] !== want.dist_mm) begin
            $error("distance_mm: expected %0d, got %0d", $signed(want.dist_mm),
                   $signed(out_tdata[DIST_W-1:0]));
            errors++;
          end
          if (out_tuser[2] !== want.valid) begin
            $error("reading_valid: expected %0d, got %0d", want.valid, out_tuser[2]);
            errors++;
          end
          if (out_tdata[15:DIST_W] !== '0) begin
            $error("out_tdata padding: expected 0, got %0d", out_tdata[15:DIST_W]);
            errors++;
          end
        end
      end
    end
  end

  // Receiver back-pressure: modes of random length
  always @(posedge clk) begin : rx_stall_proc
    static rx_mode_t mode = RX_ALWAYS;
    static int mode_left = 0;
    static int period = 2;
    static int phase_cnt = 0;
    if (mode_left == 0) begin
      mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 256);
      period = $urandom_range(2, 12);
      phase_cnt = 0;
    end else begin
      mode_left--;
    end
    case (mode)
      RX_ALWAYS:   out_tready <= 1'b1;
      RX_COIN:     out_tready <= $urandom_range(0, 1);
      RX_MOSTLY:   out_tready <= ($urandom_range(0, 7) != 0);
      RX_PERIODIC: begin
        out_tready <= (phase_cnt == 0);
        phase_cnt = (phase_cnt == period - 1) ? 0 : phase_cnt + 1;
      end
      default:     out_tready <= 1'b1;
    endcase
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sender bursts: a random gap opens each new burst when gap_max is above zero
  task automatic pace_sender(input int gap_max);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        gap = $urandom_range(1, gap_max);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw,
                             input logic [STS_W-1:0] sts, input logic typed,
                             input logic [DIST_W-1:0] dist_mm, input logic valid);
    sample_notes.push_back('{typed, dist_mm, valid});
    in_tvalid <= 1'b1;
    in_tdata  <= {sts, raw};
    in_tuser  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Stop sending and wait for every pending result, then let the pipe settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register set for one phase: fixed extremes first, random afterwards
  task automatic program_phase(input int p);
    int off [3];
    int alpha, lo, hi;
    case (p)
      0: begin off = '{-512, 511, 0};  alpha = 0;   lo = 0;    hi = 4095; end
      1: begin off = '{100, -100, 511}; alpha = 256; lo = 500;  hi = 600;  end
      2: begin off = '{-1, 1, -512};    alpha = 511; lo = 3000; hi = 100;  end
      3: begin off = '{0, 0, 0};        alpha = 1;   lo = 4095; hi = 4095; end
      default: begin
        foreach (off[i]) off[i] = int'($urandom_range(0, 1023)) - 512;
        alpha = ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
        lo = $urandom_range(0, 2000);
        hi = $urandom_range(lo, 4095);
        if ($urandom_range(0, 7) == 0) begin
          lo = $urandom_range(0, 4095);
          hi = $urandom_range(0, 4095);
        end
      end
    endcase
    // a write to an unused index must change nothing
    cfg_write(($urandom_range(0, 1) != 0) ? REG_UNUSED_6 : REG_UNUSED_7,
              CFG_DATA_W'($urandom));
    // unused upper data bits are randomised as well
    cfg_write(REG_LEFT_OFFSET,  {2'($urandom), OFF_W'(off[0])});
    cfg_write(REG_FRONT_OFFSET, {2'($urandom), OFF_W'(off[1])});
    cfg_write(REG_RIGHT_OFFSET, {2'($urandom), OFF_W'(off[2])});
    cfg_write(REG_ALPHA,        {3'($urandom), ALPHA_W'(alpha)});
    cfg_write(REG_MIN_DIST,     LIM_W'(lo));
    cfg_write(REG_MAX_DIST,     LIM_W'(hi));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus_proc
    dir_row_t dir_rows [13];
    logic [CH_W-1:0] ch;
    logic [STS_W-1:0] sts;
    int raw_i, target, kind, pick, gap_max;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // Directed samples under the reset register values
    dir_rows = '{
      '{CH_LEFT,  16'd20,    8'd0,              1'b1, 13'd20,      1'b1}, // min, seeds left
      '{CH_FRONT, 16'd2000,  8'd0,              1'b1, 13'd2000,    1'b1}, // max, seeds front
      '{CH_RIGHT, 16'd19,    8'd0,              1'b1, DIST_REJECT, 1'b0}, // just below min
      '{CH_RIGHT, 16'd2001,  8'd0,              1'b1, DIST_REJECT, 1'b0}, // just above max
      '{CH_LEFT,  16'd100,   STATUS_PHASE_FAIL, 1'b1, DIST_REJECT, 1'b0}, // phase failure
      '{CH_SPARE, 16'd100,   8'd0,              1'b1, DIST_REJECT, 1'b0}, // unknown channel
      '{CH_LEFT,  16'hFFFF,  8'hFF,             1'b1, DIST_REJECT, 1'b0}, // all ones
      '{CH_RIGHT, 16'd0,     8'd0,              1'b1, DIST_REJECT, 1'b0}, // all zeros
      '{CH_RIGHT, 16'd1000,  8'hFF,             1'b1, 13'd1000,    1'b1}, // seeds right
      '{CH_LEFT,  16'd30,    8'd0,              1'b0, 13'd0,       1'b0}, // blends from here
      '{CH_LEFT,  16'd31,    8'd3,              1'b0, 13'd0,       1'b0},
      '{CH_FRONT, 16'd1500,  8'd5,              1'b0, 13'd0,       1'b0},
      '{CH_RIGHT, 16'd1001,  8'd0,              1'b0, 13'd0,       1'b0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      pace_sender(6);
      send_sample(dir_rows[i].ch, dir_rows[i].raw, dir_rows[i].sts,
                  dir_rows[i].typed, dir_rows[i].dist_mm, dir_rows[i].valid);
    end
    drain_results();

    // Random phases, each under its own register set
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_phase(p);
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 10);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        kind = $urandom_range(0, 99);
        ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
        sts = STS_W'($urandom_range(0, 255));
        if (sts == STATUS_PHASE_FAIL) sts = '0;
        // aim the corrected distance inside the window, often right at its edges
        pick = $urandom_range(0, 9);
        if (min_mm <= max_mm)
          target = (pick == 0) ? int'(min_mm) :
                   (pick == 1) ? int'(max_mm) : $urandom_range(min_mm, max_mm);
        else
          target = $urandom_range(0, 4095);
        if (kind >= 75 && kind < 83)
          target = ($urandom_range(0, 1) != 0) ? int'(min_mm) - 1 : int'(max_mm) + 1;
        raw_i = target - ofs_mm[ch];
        if (raw_i < 0 || raw_i > 65535) raw_i = $urandom_range(0, 65535);
        if (kind >= 83 && kind < 90) begin
          sts = STATUS_PHASE_FAIL;
        end else if (kind >= 90 && kind < 95) begin
          ch = CH_SPARE;
        end else if (kind >= 95) begin
          ch = CH_W'($urandom);
          raw_i = $urandom_range(0, 65535);
          sts = STS_W'($urandom);
        end
        pace_sender(gap_max);
        send_sample(ch, RAW_W'(raw_i), sts, 1'b0, '0, 1'b0);
      end
      drain_results();
    end

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/core/rgef_pkg.sv
rtl/core/range_gate_ema_filter_core.sv
sim/range_gate_ema_filter_core_tb.sv
